// File: hdl/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// csvtok_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csvtok_pkg;

  // Field numbering limit; the index saturates at the smaller of MAX_FIELDS-1 and 255
  localparam int MAX_FIELDS      = 256;
  localparam int COUNT_LIMIT_INT = ((MAX_FIELDS - 1) > 255) ? 255 : (MAX_FIELDS - 1);
  localparam logic [7:0] COUNT_LIMIT = 8'(COUNT_LIMIT_INT);

  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_BSLASH = 8'd92;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_SEP  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       record_end;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_out;
    logic [7:0] field_index;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic       in_quotes;
    logic       escape_pending;
    logic [7:0] field_count;
  } tok_state_t;

  // Results of one byte, packed from r0; n is how many are valid (0..2)
  typedef struct packed {
    logic [1:0] n;
    res_item_t  r0;
    res_item_t  r1;
  } step_out_t;

endpackage

`default_nettype wire

// File: hdl/csvtok_step.sv
// ----------------------------------------------------------------------------
// csvtok_step
// Per-byte decode: next tokenizer state and the zero to two results it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvtok_step (
  input  csvtok_pkg::in_item_t   item,
  input  csvtok_pkg::tok_state_t st,
  output csvtok_pkg::tok_state_t st_next,
  output csvtok_pkg::step_out_t  res
);
  import csvtok_pkg::*;

  res_item_t  prim;
  res_item_t  endr;
  logic       has_prim;
  tok_state_t upd;

  always_comb begin
    upd               = st;
    has_prim          = 1'b0;
    prim.kind         = KIND_DATA;
    prim.char_out     = item.byte_in;
    prim.field_index  = st.field_count;
    prim.last         = 1'b0;

    if (st.escape_pending) begin
      // escaped byte is literal, whatever its value
      upd.escape_pending = 1'b0;
      has_prim           = 1'b1;
    end else if ((item.byte_in < CH_SPACE) || item.byte_in[7]) begin
      has_prim = 1'b0;
    end else if (item.byte_in == CH_QUOTE) begin
      upd.in_quotes = !st.in_quotes;
    end else if ((item.byte_in == CH_BSLASH) && !st.in_quotes) begin
      upd.escape_pending = 1'b1;
    end else if ((item.byte_in == CH_COMMA) && !st.in_quotes) begin
      has_prim      = 1'b1;
      prim.kind     = KIND_SEP;
      prim.char_out = 8'd0;
      if (st.field_count < COUNT_LIMIT) begin
        upd.field_count = st.field_count + 8'd1;
      end
    end else begin
      has_prim = 1'b1;
    end

    endr.kind        = KIND_END;
    endr.char_out    = 8'd0;
    endr.field_index = upd.field_count;
    endr.last        = 1'b1;

    st_next = item.record_end ? tok_state_t'('0) : upd;

    if (has_prim) begin
      prim.last = !item.record_end;
      res.r0    = prim;
      res.r1    = endr;
      res.n     = item.record_end ? 2'd2 : 2'd1;
    end else begin
      res.r0    = endr;
      res.r1    = endr;
      res.n     = item.record_end ? 2'd1 : 2'd0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/csvtok_queue.sv
// ----------------------------------------------------------------------------
// csvtok_queue
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvtok_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  csvtok_pkg::step_out_t wr,
  output logic                  full,
  output logic                  res_valid,
  input  logic                  res_stall,
  output csvtok_pkg::res_item_t res_item
);
  import csvtok_pkg::*;

  res_item_t           entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   n_push;
  logic                pop;

  assign n_push    = push ? QCNT_W'(wr.n) : '0;
  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != '0);
  assign res_item  = entries[rd_ptr];
  // room for a full two-result write, taken from registered count only
  assign full      = (count > QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + n_push - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      entries[wr_ptr] <= wr.r0;
    end
    if (n_push == QCNT_W'(2)) begin
      entries[wr_ptr + QPTR_W'(1)] <= wr.r1;
    end
  end

endmodule

`default_nettype wire

// File: hdl/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a CSV record, one byte per transfer, into data characters, field
// separators and a record-end marker, with quoting and backslash escapes.
// ----------------------------------------------------------------------------
// The results of an accepted byte are written into the result queue and offered
// from there. Throughput: one byte per cycle while each byte yields at most one
// result and the output is not stalled. A byte giving two results (kept byte or
// comma on the record's last byte) needs an extra output slot; the four-entry
// result queue absorbs it and input stalls while more than two results are queued.
// Reset clears quote/escape flags, the field count and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  csvtok_pkg::in_item_t  in_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output csvtok_pkg::res_item_t res_item
);
  import csvtok_pkg::*;

  tok_state_t st;
  tok_state_t st_next;
  step_out_t  step_res;
  logic       accept;
  logic       q_full;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  csvtok_step u_step (
    .item    (in_item),
    .st      (st),
    .st_next (st_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  csvtok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .wr        (step_res),
    .full      (q_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

`default_nettype wire

// File: hdl/csvtok_checker.sv
// ----------------------------------------------------------------------------
// csvtok_checker
// Port-level checks on the tokenizer's result channel and reset behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvtok_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  res_valid,
  input logic                  res_stall,
  input csvtok_pkg::res_item_t res_item
);
  import csvtok_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // record end is always the final result of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == KIND_END) |-> res_item.last)
    else $error("record end without last");

  // only data results carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind != KIND_DATA) |-> (res_item.char_out == 8'd0))
    else $error("non-data result with character");

  // reset empties the queue and opens the input
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind csv_field_tokenizer csvtok_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

`default_nettype wire

// File: sim/csvtok_checker.sv
// ----------------------------------------------------------------------------
// csvtok_monitor
// Watches both channels of the CSV field tokenizer. It runs its own copy of
// the quote, escape and field-count state on every accepted byte, queues the
// tokens that byte should give, and compares each accepted result against the
// oldest queued token, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csvtok_monitor (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  csvtok_pkg::in_item_t  in_item,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  csvtok_pkg::res_item_t res_item,
  output int unsigned           mismatches,
  output int unsigned           tokens_pending,
  output int unsigned           tokens_checked
);
  import csvtok_pkg::*;

  logic        quoted       = 1'b0;
  logic        escape_armed = 1'b0;
  logic [7:0]  field_no     = 8'd0;
  res_item_t   expected_tokens [$];
  int unsigned err_count    = 0;
  int unsigned ok_count     = 0;

  initial begin
    mismatches     = 0;
    tokens_pending = 0;
    tokens_checked = 0;
  end

  function automatic res_item_t make_token(input kind_t k, input logic [7:0] c,
                                           input logic [7:0] idx);
    res_item_t t;
    t.kind        = k;
    t.char_out    = c;
    t.field_index = idx;
    t.last        = 1'b0;
    return t;
  endfunction

  // Advance the tokenizer state by one byte and queue the tokens it yields
  function automatic void tokenize_byte(input in_item_t item);
    res_item_t  produced [$];
    logic [7:0] b;
    b = item.byte_in;
    if (escape_armed) begin
      // escaped byte is literal, whatever it is
      escape_armed = 1'b0;
      produced.push_back(make_token(KIND_DATA, b, field_no));
    end else if (b < CH_SPACE || b[7]) begin
      // control or high byte: dropped
    end else if (b == CH_QUOTE) begin
      quoted = ~quoted;
    end else if (b == CH_BSLASH && !quoted) begin
      escape_armed = 1'b1;
    end else if (b == CH_COMMA && !quoted) begin
      produced.push_back(make_token(KIND_SEP, 8'd0, field_no));
      if (field_no < COUNT_LIMIT)
        field_no = field_no + 8'd1;
    end else begin
      produced.push_back(make_token(KIND_DATA, b, field_no));
    end
    if (item.record_end) begin
      produced.push_back(make_token(KIND_END, 8'd0, field_no));
      quoted       = 1'b0;
      escape_armed = 1'b0;
      field_no     = 8'd0;
    end
    if (produced.size() > 0)
      produced[produced.size() - 1].last = 1'b1;
    foreach (produced[i])
      expected_tokens.push_back(produced[i]);
  endfunction

  always @(posedge clk) begin : monitor
    res_item_t want;
    if (rst) begin
      quoted       = 1'b0;
      escape_armed = 1'b0;
      field_no     = 8'd0;
      expected_tokens.delete();
    end else begin
      if (in_valid && !in_stall)
        tokenize_byte(in_item);
      if (res_valid && !res_stall) begin
        if (expected_tokens.size() == 0) begin
          err_count++;
          $display("%0t: unexpected token kind=%0d char=%02h field=%0d last=%0b",
                   $time, res_item.kind, res_item.char_out, res_item.field_index,
                   res_item.last);
        end else begin
          want = expected_tokens.pop_front();
          if (res_item.kind !== want.kind || res_item.char_out !== want.char_out ||
              res_item.field_index !== want.field_index ||
              res_item.last !== want.last) begin
            err_count++;
            $display("%0t: token mismatch: expected kind=%0d char=%02h field=%0d last=%0b",
                     $time, want.kind, want.char_out, want.field_index, want.last);
            $display("%0t:                 actual   kind=%0d char=%02h field=%0d last=%0b",
                     $time, res_item.kind, res_item.char_out, res_item.field_index,
                     res_item.last);
          end else begin
            ok_count++;
          end
        end
      end
    end
    mismatches     <= err_count;
    tokens_pending <= expected_tokens.size();
    tokens_checked <= ok_count;
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the CSV field tokenizer with a directed record covering dropped bytes,
// quoting, escapes and record ends, then random records and noise under four
// flow-control mixes, the last of which opens with a record that runs the field
// count into saturation. Checking is done by csvtok_monitor alongside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import csvtok_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_item_t   res_item;

  int unsigned mismatches;
  int unsigned tokens_pending;
  int unsigned tokens_checked;

  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int          bytes_sent  = 0;
  int          records     = 0;
  int          gap_mix   [4] = '{0, 59, 0, 32};
  int          stall_mix [4] = '{0, 0, 59, 32};

  always #1 clk = ~clk;

  csv_field_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  csvtok_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .res_item       (res_item),
    .mismatches     (mismatches),
    .tokens_pending (tokens_pending),
    .tokens_checked (tokens_checked)
  );

  always @(posedge clk) begin
    res_stall <= !rst && stall_pct != 0 && ($urandom_range(99) < stall_pct);
  end

  // Offer one byte, with a random gap first, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic eor);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{byte_in: b, record_end: eor};
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    bytes_sent++;
    if (eor)
      records++;
  endtask

  // Byte mix weighted towards the characters that steer the tokenizer
  function automatic logic [7:0] pick_csv_byte();
    int r = $urandom_range(99);
    if (r < 40)
      return 8'($urandom_range(126, 32));
    else if (r < 55)
      return CH_COMMA;
    else if (r < 65)
      return CH_QUOTE;
    else if (r < 75)
      return CH_BSLASH;
    else if (r < 85)
      return 8'($urandom_range(31, 0));
    else if (r < 92)
      return 8'($urandom_range(255, 128));
    else
      return 8'($urandom_range(255, 0));
  endfunction

  initial begin : stimulus
    int phase;
    int sent_in_phase;
    int len;
    int commas;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // control and high bytes are dropped; the printable edges 20h and 7fh are kept
    send_byte(8'h00, 1'b0);
    send_byte(8'h1f, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    // comma and backslash inside quotes are plain data
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_COMMA, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    // escapes make anything literal
    send_byte(CH_BSLASH, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_COMMA, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(CH_COMMA, 1'b0);
    send_byte(8'h78, 1'b1);         // kept byte on record end: two tokens
    send_byte(CH_COMMA, 1'b1);      // separator then record end
    send_byte(CH_BSLASH, 1'b1);     // pending escape discarded
    send_byte(8'h05, 1'b1);         // dropped byte, record end only
    send_byte(CH_QUOTE, 1'b0);      // open quote left hanging at the end
    send_byte(8'h61, 1'b1);
    send_byte(CH_COMMA, 1'b1);      // quoting must be cleared again

    for (phase = 0; phase < 4; phase++) begin
      gap_pct   = gap_mix[phase];
      stall_pct = stall_mix[phase];
      if (phase == 3) begin
        // enough commas to run the field index into saturation
        commas = 0;
        while (commas < 262) begin
          if ($urandom_range(7) == 0) begin
            send_byte(8'(8'h61 + $urandom_range(25)), 1'b0);
          end else begin
            send_byte(CH_COMMA, 1'b0);
            commas++;
          end
        end
        send_byte(8'h7a, 1'b1);
      end
      sent_in_phase = 0;
      while (sent_in_phase < 100) begin
        if ($urandom_range(99) < 15) begin
          // noise: any byte, record ends anywhere
          len = $urandom_range(10, 1);
          for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
          len = $urandom_range(24, 1);
          for (int i = 0; i < len; i++)
            send_byte(pick_csv_byte(), i == len - 1);
        end
        sent_in_phase += len;
      end
    end
    in_valid  <= 1'b0;
    stall_pct = 0;

    @(posedge clk);
    while (tokens_pending != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    $display("summary: %0d bytes in %0d records, %0d tokens matched,", bytes_sent, records,
             tokens_checked);
    $display("summary: field saturation plus free-running, idle-sender and stalled-receiver mixes");
    if (mismatches == 0 && tokens_pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (tokens_pending != 0)
        $display("%0t: %0d expected tokens never arrived", $time, tokens_pending);
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("%0t: timed out", $time);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
